### src/htq_pkg.sv
// Shared types, constants and the entry ordering function for the heap timer queue.
// Depends on nothing; used by htq_cell, heap_timer_queue_core and the testbench.
`timescale 1ns / 1ps
package htq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int MAX_FIRE     = 64;
    localparam int DL_W         = 48;
    localparam int ID_W         = 31;
    localparam int DUR_W        = 32;
    localparam int FC_W         = 7;

    // Operation codes of an input item
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    // Cell operations
    localparam logic [1:0] OP_HOLD    = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_SHL_ALL = 2'd2;
    localparam logic [1:0] OP_SHL_HIT = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [DL_W-1:0]  now_ms;
        logic [DUR_W-1:0] duration_ms;
        logic [ID_W-1:0]  cancel_id;
    } t_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] tmr_id;
        logic            is_last;
        logic [FC_W-1:0] fired_count;
    } t_result;

    typedef struct packed {
        logic [DL_W-1:0] dl;
        logic [ID_W-1:0] id;
    } t_entry;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic [1:0] op;
        t_entry     ent;
    } t_cell_ctl;

    // Earlier deadline first; on a tie the larger id first
    function automatic logic sorts_before(input t_entry a, input t_entry b);
        if (a.dl == b.dl) begin
            return a.id > b.id;
        end
        return a.dl < b.dl;
    endfunction

endpackage

### src/htq_cell.sv
// One slot of the sorted timer chain: holds an entry and trades it with its neighbors.
// Depends on htq_pkg.
`timescale 1ns / 1ps
module htq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htq_pkg::t_cell_ctl i_ctl,
    input  htq_pkg::t_entry   i_left,
    input  logic              i_left_vld,
    input  logic              i_left_lt,
    input  htq_pkg::t_entry   i_right,
    input  logic              i_right_vld,
    input  logic              i_hit_in,
    output htq_pkg::t_entry   o_entry,
    output logic              o_vld,
    output logic              o_lt,
    output logic              o_hit
);
    import htq_pkg::*;

    t_entry r_entry, n_entry;
    logic   r_vld, n_vld;
    logic   lt, hit;

    // New entry goes before this slot, or this slot is empty
    assign lt  = !r_vld || sorts_before(i_ctl.ent, r_entry);
    // A match at or before this slot
    assign hit = i_hit_in || (r_vld && (r_entry.id == i_ctl.ent.id));

    always_comb begin
        n_entry = r_entry;
        n_vld   = r_vld;
        case (i_ctl.op)
            OP_INSERT: begin
                if (lt) begin
                    if (i_left_lt) begin
                        n_entry = i_left;
                        n_vld   = i_left_vld;
                    end else begin
                        n_entry = i_ctl.ent;
                        n_vld   = 1'b1;
                    end
                end
            end
            OP_SHL_ALL: begin
                n_entry = i_right;
                n_vld   = i_right_vld;
            end
            OP_SHL_HIT: begin
                if (hit) begin
                    n_entry = i_right;
                    n_vld   = i_right_vld;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_entry = r_entry;
    assign o_vld   = r_vld;
    assign o_lt    = lt;
    assign o_hit   = hit;

endmodule

### src/heap_timer_queue_core.sv
// Top level of the timer queue: sequencer, counters and the sorted chain of cells.
// Depends on htq_pkg and htq_cell.
`timescale 1ns / 1ps
// Usage:
//   Drive i_item and raise start; the item is taken on a clock edge where busy
//   is low. Results appear on o_result for one cycle each, flagged by o_done;
//   the receiver must take them as they come, there is no back-pressure.
//   Timers live in a chain of CAPACITY cells kept in expiry order, cell 0
//   holding the next timer to fire. Every cell compares against the broadcast
//   entry in parallel.
//   Start forms the deadline at accept and inserts in the next cycle, in the
//   insert state, which also registers its result. A full queue answers the
//   cycle after accept. Cancel closes the gap in the chain in the cancel
//   state, which also registers its result.
//   Update pops one fired timer per cycle: N fired timers give N results on
//   consecutive cycles, the first from the update state; with none due a
//   single "none fired" result follows. busy drops in the cycle the last
//   result is shown, so the next item can be taken at the edge ending it.
//   busy stays high until an item's last result is registered, so each item
//   is finished before the next is taken; an update fires at most 64 timers.
//   Reset (synchronous, active low) empties the queue and sets the next id
//   to one; slot contents are left as they are.
module heap_timer_queue_core #(
    parameter int CAPACITY = htq_pkg::DEF_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  htq_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_done,
    output htq_pkg::t_result o_result
);
    import htq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_CAN  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ID_W-1:0] r_next_id, n_next_id;
    t_entry          r_ent, n_ent;
    logic [DL_W-1:0] r_now, n_now;
    logic [FC_W-1:0] r_fired, n_fired;
    logic            r_done, n_done;
    t_result         r_res, n_res;

    t_cell_ctl       ctl;
    t_entry          c_ent [CAPACITY];
    logic            c_vld [CAPACITY];
    logic            c_lt  [CAPACITY];
    logic            c_hit [CAPACITY];

    logic            accept;
    logic [DL_W:0]   dl_sum;
    logic            fire;
    logic            next_due;
    logic [FC_W-1:0] fired_inc;

    // Build the chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry left_ent, right_ent;
        logic   left_vld, left_lt, right_vld, hit_in;
        if (g == 0) begin : g_head
            assign left_ent = '0;
            assign left_vld = 1'b0;
            assign left_lt  = 1'b0;
            assign hit_in   = 1'b0;
        end else begin : g_mid
            assign left_ent = c_ent[g-1];
            assign left_vld = c_vld[g-1];
            assign left_lt  = c_lt[g-1];
            assign hit_in   = c_hit[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_ent = '0;
            assign right_vld = 1'b0;
        end else begin : g_body
            assign right_ent = c_ent[g+1];
            assign right_vld = c_vld[g+1];
        end
        htq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_left      (left_ent),
            .i_left_vld  (left_vld),
            .i_left_lt   (left_lt),
            .i_right     (right_ent),
            .i_right_vld (right_vld),
            .i_hit_in    (hit_in),
            .o_entry     (c_ent[g]),
            .o_vld       (c_vld[g]),
            .o_lt        (c_lt[g]),
            .o_hit       (c_hit[g])
        );
    end

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Saturating deadline
    assign dl_sum = {1'b0, i_item.now_ms} + {{(DL_W + 1 - DUR_W){1'b0}}, i_item.duration_ms};

    // Head of chain due, and whether the one behind it is due too
    assign fire      = c_vld[0] && (c_ent[0].dl <= r_now);
    assign next_due  = c_vld[1] && (c_ent[1].dl <= r_now);
    assign fired_inc = r_fired + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_next_id = r_next_id;
        n_ent     = r_ent;
        n_now     = r_now;
        n_fired   = r_fired;
        n_done    = 1'b0;
        n_res     = r_res;
        ctl.op    = OP_HOLD;
        ctl.ent   = r_ent;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.func)
                        FUNC_START: begin
                            if (r_cnt == CNT_W'(CAPACITY)) begin
                                n_done = 1'b1;
                                n_res  = '{status: ST_FULL, tmr_id: '0,
                                           is_last: 1'b1, fired_count: '0};
                            end else begin
                                n_ent.dl = dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0];
                                n_state  = S_INS;
                            end
                        end
                        FUNC_CANCEL: begin
                            n_ent.id = i_item.cancel_id;
                            n_state  = S_CAN;
                        end
                        FUNC_UPDATE: begin
                            n_now   = i_item.now_ms;
                            n_fired = '0;
                            n_state = S_UPD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                // Insert with the next id and hand it back
                ctl.op     = OP_INSERT;
                ctl.ent.id = r_next_id;
                n_cnt      = r_cnt + 1'b1;
                n_next_id  = (r_next_id == {ID_W{1'b1}}) ? ID_W'(1) : r_next_id + 1'b1;
                n_done     = 1'b1;
                n_res      = '{status: ST_OK, tmr_id: r_next_id,
                               is_last: 1'b1, fired_count: '0};
                n_state    = S_IDLE;
            end
            S_CAN: begin
                // Close the gap behind the first match
                ctl.op = OP_SHL_HIT;
                n_done = 1'b1;
                if (c_hit[CAPACITY-1]) begin
                    n_cnt = r_cnt - 1'b1;
                    n_res = '{status: ST_OK, tmr_id: r_ent.id,
                              is_last: 1'b1, fired_count: '0};
                end else begin
                    n_res = '{status: ST_NOT_FOUND, tmr_id: r_ent.id,
                              is_last: 1'b1, fired_count: '0};
                end
                n_state = S_IDLE;
            end
            S_UPD: begin
                // Pop one due timer a cycle
                n_done = 1'b1;
                if (fire) begin
                    ctl.op  = OP_SHL_ALL;
                    n_cnt   = r_cnt - 1'b1;
                    n_fired = fired_inc;
                    n_res   = '{status: ST_OK, tmr_id: c_ent[0].id,
                                is_last: !next_due || (fired_inc == FC_W'(MAX_FIRE)),
                                fired_count: fired_inc};
                    if (!next_due || (fired_inc == FC_W'(MAX_FIRE))) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_res   = '{status: ST_NONE, tmr_id: '0,
                                is_last: 1'b1, fired_count: '0};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_now   <= n_now;
        r_fired <= n_fired;
        r_res   <= n_res;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_next_id <= ID_W'(1);
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_next_id <= n_next_id;
            r_done    <= n_done;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### verif/tb_heap_timer_queue_core.sv
// Self-checking testbench for heap_timer_queue_core: directed and random items.
// Depends on htq_pkg and the heap_timer_queue_core RTL; predicts results in a sorted queue.
`timescale 1ns / 1ps
module tb_heap_timer_queue_core;
    import htq_pkg::*;

    localparam int QCAP      = DEF_CAPACITY;
    localparam int CYCLE_MAX = 400000;
    localparam logic [1:0] FUNC_BAD = 2'd3;
    localparam logic [DL_W-1:0]  DL_MAX  = '1;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // Pending timers in expiry order and results still owed by the block
    t_entry  timers_q[$];
    t_result owed_q[$];
    logic [ID_W-1:0] next_id;
    logic [DL_W-1:0] clock_ms;
    int      err_cnt;
    int      cycle_cnt;
    bit      no_gaps;

    heap_timer_queue_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Generate the 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Abort on a hang
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("[heap_timer_queue_core] ERROR");
            $finish;
        end
    end

    // Check each result against the oldest owed one
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_done) begin
            if (owed_q.size() == 0) begin
                $error("unexpected result status=%0d tmr_id=%0d",
                       o_result.status, o_result.tmr_id);
                err_cnt++;
            end else begin
                exp_r = owed_q.pop_front();
                if (o_result.status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_result.status);
                    err_cnt++;
                end
                if (o_result.tmr_id !== exp_r.tmr_id) begin
                    $error("tmr_id expected %0d actual %0d",
                           exp_r.tmr_id, o_result.tmr_id);
                    err_cnt++;
                end
                if (o_result.is_last !== exp_r.is_last) begin
                    $error("is_last expected %0d actual %0d", exp_r.is_last, o_result.is_last);
                    err_cnt++;
                end
                if (o_result.fired_count !== exp_r.fired_count) begin
                    $error("fired_count expected %0d actual %0d",
                           exp_r.fired_count, o_result.fired_count);
                    err_cnt++;
                end
            end
        end
    end

    function automatic logic entry_first(t_entry a, t_entry b);
        if (a.dl == b.dl) begin
            return a.id > b.id;
        end
        return a.dl < b.dl;
    endfunction

    function automatic t_result mk_result(logic [1:0] st, logic [ID_W-1:0] id,
                                          logic last, logic [FC_W-1:0] cnt);
        t_result r;
        r.status      = st;
        r.tmr_id      = id;
        r.is_last     = last;
        r.fired_count = cnt;
        return r;
    endfunction

    // Append one result to the owed list
    function automatic void owe_result(t_result r);
        owed_q.insert(owed_q.size(), r);
    endfunction

    // Work out the results of one accepted item and advance the timer list
    task automatic predict_timers(t_item it);
        logic [DL_W:0] sum;
        t_entry        ent;
        int            pos;
        int            fired;
        bit            hit;
        case (it.func)
            FUNC_START: begin
                if (timers_q.size() >= QCAP) begin
                    owe_result(mk_result(ST_FULL, '0, 1'b1, '0));
                end else begin
                    sum = it.now_ms + it.duration_ms;
                    ent.dl = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];
                    ent.id = next_id;
                    next_id = (next_id == '1) ? ID_W'(1) : next_id + 1'b1;
                    pos = timers_q.size();
                    for (int i = 0; i < timers_q.size(); i++) begin
                        if (entry_first(ent, timers_q[i])) begin
                            pos = i;
                            break;
                        end
                    end
                    timers_q.insert(pos, ent);
                    owe_result(mk_result(ST_OK, ent.id, 1'b1, '0));
                end
            end
            FUNC_CANCEL: begin
                hit = 0;
                for (int i = 0; i < timers_q.size(); i++) begin
                    if (timers_q[i].id == it.cancel_id) begin
                        timers_q.delete(i);
                        hit = 1;
                        break;
                    end
                end
                owe_result(mk_result(hit ? ST_OK : ST_NOT_FOUND,
                                     it.cancel_id, 1'b1, '0));
            end
            FUNC_UPDATE: begin
                fired = 0;
                while (timers_q.size() > 0 && fired < MAX_FIRE
                       && timers_q[0].dl <= it.now_ms) begin
                    ent = timers_q.pop_front();
                    fired++;
                    owe_result(mk_result(ST_OK, ent.id, 1'b0, FC_W'(fired)));
                end
                if (fired == 0) begin
                    owe_result(mk_result(ST_NONE, '0, 1'b1, '0));
                end else begin
                    owed_q[owed_q.size()-1].is_last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Present one item and hold it until the block takes it
    task automatic send_item(logic [1:0] fn, logic [DL_W-1:0] now,
                             logic [DUR_W-1:0] dur, logic [ID_W-1:0] cid);
        t_item it;
        it.func        = fn;
        it.now_ms      = now;
        it.duration_ms = dur;
        it.cancel_id   = cid;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_timers(it);
        if (!no_gaps && $urandom_range(99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every owed result is back
    task automatic drain_results();
        start <= 1'b0;
        while (owed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_corners();
        send_item(FUNC_UPDATE, '0, '0, '0);             // none fired on empty
        send_item(FUNC_CANCEL, '0, '0, '1);             // miss on empty
        send_item(FUNC_START, DL_MAX, DUR_MAX, '0);     // deadline saturates
        send_item(FUNC_START, '0, DUR_MAX, '1);
        send_item(FUNC_START, 48'd100, 32'd0, '0);
        send_item(FUNC_START, 48'd50, 32'd50, '0);      // tie: larger id first
        send_item(FUNC_START, 48'd100, 32'd0, '0);
        send_item(FUNC_BAD, DL_MAX, DUR_MAX, '1);       // ignored
        send_item(FUNC_CANCEL, '0, '0, 31'd4);
        send_item(FUNC_CANCEL, '0, '0, 31'd4);          // already gone
        send_item(FUNC_UPDATE, 48'd99, '0, '0);
        send_item(FUNC_UPDATE, 48'd100, '0, '0);
        send_item(FUNC_UPDATE, DL_MAX - 1, '0, '0);
        send_item(FUNC_UPDATE, DL_MAX, '0, '0);
        drain_results();
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < QCAP; i++) begin
            send_item(FUNC_START, 48'd1000, $urandom_range(0, 20), '0);
        end
        send_item(FUNC_START, '0, '0, '0);              // full
        send_item(FUNC_UPDATE, DL_MAX, '0, '0);         // all 64 fire
        send_item(FUNC_UPDATE, DL_MAX, '0, '0);
        drain_results();
    endtask

    task automatic test_random(int n_items);
        int              pick;
        logic [DUR_W-1:0] dur;
        logic [ID_W-1:0]  cid;
        clock_ms = 0;
        for (int k = 0; k < n_items; k++) begin
            no_gaps = (k >= 120 && k < 200);
            pick = $urandom_range(99);
            if (pick < 45) begin
                dur = ($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 300);
                send_item(FUNC_START, clock_ms, dur, '0);
            end else if (pick < 65) begin
                if (timers_q.size() > 0 && $urandom_range(4) != 0) begin
                    cid = timers_q[$urandom_range(timers_q.size() - 1)].id;
                end else begin
                    cid = ID_W'($urandom);
                end
                send_item(FUNC_CANCEL, clock_ms, $urandom, cid);
            end else if (pick < 97) begin
                clock_ms = clock_ms + $urandom_range(0, 150);
                send_item(FUNC_UPDATE, clock_ms, $urandom, ID_W'($urandom));
            end else begin
                send_item(FUNC_BAD, DL_W'({$urandom, $urandom}), $urandom,
                          ID_W'($urandom));
            end
            if (k == 250) begin
                drain_results();
            end
        end
        no_gaps = 0;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_item    = '0;
        next_id   = 1;
        err_cnt   = 0;
        cycle_cnt = 0;
        no_gaps   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_full_queue();
        test_random(340);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[heap_timer_queue_core] OK");
        end else begin
            $display("[heap_timer_queue_core] ERROR");
        end
        $finish;
    end
endmodule

### files.f
src/htq_pkg.sv
src/htq_cell.sv
src/heap_timer_queue_core.sv
verif/tb_heap_timer_queue_core.sv
